[rtl/core/ootf_pkg.sv]
`timescale 1ns / 1ps

package ootf_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int DATA_W        = 24;
  localparam int SEQ_W         = 8;
  localparam int WORD_W        = DATA_W + SEQ_W;
  localparam int COUNT_W       = 8;

  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // request taken this cycle: update pointers and store
    logic load;      // load the result register
    logic from_mem;  // result carries the word read from the store
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pop_hit;   // request is a pop that finds an entry
  } status_t;

endpackage

[rtl/core/overwrite_oldest_tagged_fifo.sv]
`timescale 1ns / 1ps

// Overwriting ring-buffer FIFO of 32-bit tagged words: each push stores the
// 24-bit sample under an 8-bit wrapping sequence number and always succeeds,
// dropping the oldest entry when the DEPTH-1 capacity is reached; a pop
// returns the oldest word, or all ones with pop_was_empty set; a clear zeroes
// both pointers but keeps the stored words, the sequence number and the
// newest word. Every request yields one result carrying the occupancy, the
// data-available flag and the most recently pushed word. A push, a clear, an
// unused action code or a pop of an empty FIFO loads its result when taken,
// so such requests stream at one per cycle while results drain; a pop that
// finds an entry passes the read state for the store's registered read port.
// The result register parts the two sides, so a new request is taken as the
// previous result is drained. The store needs no clearing pass after reset.

module overwrite_oldest_tagged_fifo
  import ootf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [DATA_W-1:0]  sample_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WORD_W-1:0]  popped_word,
  output logic               pop_was_empty,
  output logic [COUNT_W-1:0] entry_count,
  output logic               data_available,
  output logic [WORD_W-1:0]  newest_word
);

  cmd_t    cmd;
  status_t status;

  // Sequence requests and the result register handshake
  ootf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold pointers, sequence counter, word store and result register
  ootf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .action         (action),
    .sample_data    (sample_data),
    .popped_word    (popped_word),
    .pop_was_empty  (pop_was_empty),
    .entry_count    (entry_count),
    .data_available (data_available),
    .newest_word    (newest_word)
  );

endmodule

[rtl/core/ootf_ctrl.sv]
`timescale 1ns / 1ps

module ootf_ctrl
  import ootf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.load     = 1'b0;
    cmd.from_mem = 1'b0;
    case (state)
      ST_IDLE: begin
        // take a request once the result register is free or being drained
        in_ready   = !out_valid || out_ready;
        cmd.accept = in_valid && in_ready;
        if (cmd.accept) begin
          if (status.pop_hit) begin
            state_next = ST_READ;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.load     = 1'b1;
        cmd.from_mem = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

[rtl/core/ootf_datapath.sv]
`timescale 1ns / 1ps

module ootf_datapath
  import ootf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [1:0]         action,
  input  logic [DATA_W-1:0]  sample_data,
  output logic [WORD_W-1:0]  popped_word,
  output logic               pop_was_empty,
  output logic [COUNT_W-1:0] entry_count,
  output logic               data_available,
  output logic [WORD_W-1:0]  newest_word
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] LAST     = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CW = CNT_W'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] mem_q;

  logic [PTR_W-1:0]  rd;
  logic [PTR_W-1:0]  wr;
  logic [PTR_W-1:0]  rd_next;
  logic [PTR_W-1:0]  wr_next;
  logic [PTR_W-1:0]  rd_adv;
  logic [PTR_W-1:0]  wr_adv;
  logic [SEQ_W-1:0]  seq;
  logic [WORD_W-1:0] push_word;
  logic              is_push;
  logic              is_pop;
  logic              empty;
  logic [CNT_W-1:0]  count;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  assign rd_adv    = (rd == LAST) ? '0 : rd + 1'b1;
  assign wr_adv    = (wr == LAST) ? '0 : wr + 1'b1;
  assign empty     = (rd == wr);
  assign push_word = {seq, sample_data};

  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    rd_next = rd;
    wr_next = wr;
    case (action_t'(action))
      ACT_PUSH: begin
        is_push = 1'b1;
        if (cmd.accept) begin
          wr_next = wr_adv;
          // full: drop the oldest entry
          if (wr_adv == rd) begin
            rd_next = rd_adv;
          end
        end
      end
      ACT_POP: begin
        is_pop = 1'b1;
        if (cmd.accept && !empty) begin
          rd_next = rd_adv;
        end
      end
      ACT_CLEAR: begin
        if (cmd.accept) begin
          rd_next = '0;
          wr_next = '0;
        end
      end
      default: begin
        is_push = 1'b0;
      end
    endcase
  end

  assign status.pop_hit = is_pop && !empty;

  // occupancy after the request, modulo DEPTH
  always_comb begin
    if (wr_next >= rd_next) begin
      count = {1'b0, wr_next} - {1'b0, rd_next};
    end else begin
      count = {1'b0, wr_next} + DEPTH_CW - {1'b0, rd_next};
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      rd          <= '0;
      wr          <= '0;
      seq         <= '0;
      newest_word <= '0;
    end else begin
      rd <= rd_next;
      wr <= wr_next;
      if (cmd.accept && is_push) begin
        seq         <= seq + 1'b1;
        newest_word <= push_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_push) begin
      mem[wr] <= push_word;
    end
    if (cmd.accept) begin
      mem_q <= mem[rd];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      popped_word    <= cmd.from_mem ? mem_q : ALL_ONES;
      pop_was_empty  <= !cmd.from_mem && is_pop && empty;
      entry_count    <= count_ext[COUNT_W-1:0];
      data_available <= (rd_next != wr_next);
    end
  end

endmodule
